FILE: src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and codes for the LFU cache table: opcodes, the capacity
// width and reset value, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	typedef logic [31:0] word_t;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam int unsigned CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: src/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a request, sweep the entry store, then commit the
// update and load the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  lfu_pkg::status_t status,
	output lfu_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WB
	} state_t;

	state_t state_q;

	always_comb begin
		cmd        = '0;
		in_stall   = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.start  = in_valid;
			ST_SCAN: cmd.scan   = 1'b1;
			ST_WB:   cmd.commit = status.out_free;
			default: cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SCAN;
				ST_SCAN: if (status.scan_last) state_q <= ST_WB;
				ST_WB:   if (status.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// Entry store, scan pipeline (key match, first free slot, LFU/oldest
// victim), write-back and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_dp #(
	parameter int unsigned ENTRIES = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  lfu_pkg::cmd_t               cmd,
	output lfu_pkg::status_t            status,
	input  wire                         cfg_we,
	input  wire [lfu_pkg::CAP_W-1:0]    cfg_wdata,
	input  wire                         opcode,
	input  wire [31:0]                  lookup_key,
	input  wire [31:0]                  write_value,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic                        hit,
	output logic [31:0]                 read_value,
	output logic                        evicted,
	output logic [31:0]                 evicted_key
);

	localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned OW   = $clog2(ENTRIES + 1);
	localparam int unsigned CMPW = (OW > lfu_pkg::CAP_W) ? OW : lfu_pkg::CAP_W;
	localparam logic [IW:0] LAST = (IW+1)'(ENTRIES);

	lfu_pkg::word_t key_mem   [ENTRIES];
	lfu_pkg::word_t val_mem   [ENTRIES];
	lfu_pkg::word_t cnt_mem   [ENTRIES];
	lfu_pkg::word_t stamp_mem [ENTRIES];

	logic [ENTRIES-1:0]        valid_q;
	logic [OW-1:0]             occ_q;
	lfu_pkg::word_t            clock_q;
	logic [lfu_pkg::CAP_W-1:0] cap_q;

	logic            op_q;
	lfu_pkg::word_t  key_q;
	lfu_pkg::word_t  val_q;

	logic [IW:0]     addr_q;

	logic            live_s1;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	lfu_pkg::word_t  key_s1;
	lfu_pkg::word_t  val_s1;
	lfu_pkg::word_t  cnt_s1;
	lfu_pkg::word_t  stamp_s1;

	logic            found_q;
	logic [IW-1:0]   match_idx_q;
	lfu_pkg::word_t  match_val_q;
	lfu_pkg::word_t  match_cnt_q;
	logic            free_found_q;
	logic [IW-1:0]   free_idx_q;
	logic            vic_found_q;
	logic [IW-1:0]   vic_idx_q;
	lfu_pkg::word_t  vic_cnt_q;
	lfu_pkg::word_t  vic_age_q;
	lfu_pkg::word_t  vic_key_q;

	lfu_pkg::word_t  age_s1;
	logic            take_vic;
	logic [CMPW-1:0] cap_ext;
	logic [CMPW-1:0] ent_ext;
	logic [CMPW-1:0] eff_cap;
	logic            room;
	logic            reading;
	logic [IW-1:0]   rd_idx;

	logic            wr_en;
	logic [IW-1:0]   wr_idx;
	logic            wr_key;
	logic            wr_val;
	lfu_pkg::word_t  wr_cnt;

	assign reading = cmd.scan && (addr_q < LAST);
	assign rd_idx  = addr_q[IW-1:0];

	assign status.scan_last = (addr_q == LAST);
	assign status.out_free  = !out_valid || !out_stall;

	assign age_s1   = clock_q - stamp_s1;
	assign take_vic = vld_s1 && (!vic_found_q || (cnt_s1 < vic_cnt_q) ||
		((cnt_s1 == vic_cnt_q) && (age_s1 > vic_age_q)));

	assign cap_ext = CMPW'(cap_q);
	assign ent_ext = CMPW'(ENTRIES);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_ext > ent_ext) begin
			eff_cap = ent_ext;
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign room = (CMPW'(occ_q) < eff_cap);

	// write-back decision
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = match_idx_q;
		wr_key = 1'b0;
		wr_val = 1'b0;
		wr_cnt = (match_cnt_q == '1) ? match_cnt_q : match_cnt_q + 32'd1;
		if (cmd.commit) begin
			if (found_q) begin
				wr_en  = 1'b1;
				wr_val = (op_q == lfu_pkg::OP_PUT);
			end else if (op_q == lfu_pkg::OP_PUT) begin
				wr_en  = 1'b1;
				wr_key = 1'b1;
				wr_val = 1'b1;
				wr_cnt = 32'd1;
				wr_idx = room ? free_idx_q : vic_idx_q;
			end
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (reading) begin
			key_s1   <= key_mem[rd_idx];
			val_s1   <= val_mem[rd_idx];
			cnt_s1   <= cnt_mem[rd_idx];
			stamp_s1 <= stamp_mem[rd_idx];
		end
		if (wr_en) begin
			cnt_mem[wr_idx]   <= wr_cnt;
			stamp_mem[wr_idx] <= clock_q;
			if (wr_key) key_mem[wr_idx] <= key_q;
			if (wr_val) val_mem[wr_idx] <= val_q;
		end
	end

	// request and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= opcode;
			key_q <= lookup_key;
			val_q <= write_value;
		end
		idx_s1 <= rd_idx;
		vld_s1 <= reading && valid_q[rd_idx];
		if (live_s1) begin
			if (vld_s1 && (key_s1 == key_q) && !found_q) begin
				match_idx_q <= idx_s1;
				match_val_q <= val_s1;
				match_cnt_q <= cnt_s1;
			end
			if (!vld_s1 && !free_found_q) free_idx_q <= idx_s1;
			if (take_vic) begin
				vic_idx_q <= idx_s1;
				vic_cnt_q <= cnt_s1;
				vic_age_q <= age_s1;
				vic_key_q <= key_s1;
			end
		end
		if (cmd.commit) begin
			hit         <= found_q;
			read_value  <= (found_q && (op_q == lfu_pkg::OP_GET)) ? match_val_q : '0;
			evicted     <= !found_q && (op_q == lfu_pkg::OP_PUT) && !room;
			evicted_key <= (!found_q && (op_q == lfu_pkg::OP_PUT) && !room) ?
				vic_key_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			occ_q        <= '0;
			clock_q      <= '0;
			cap_q        <= lfu_pkg::CAP_RESET;
			addr_q       <= '0;
			live_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			live_s1 <= reading;
			if (cmd.start) begin
				addr_q       <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				vic_found_q  <= 1'b0;
			end else if (reading) begin
				addr_q <= addr_q + 1'b1;
			end
			if (live_s1) begin
				if (vld_s1 && (key_s1 == key_q)) found_q <= 1'b1;
				if (!vld_s1) free_found_q <= 1'b1;
				if (vld_s1) vic_found_q <= 1'b1;
			end
			if (wr_en) begin
				clock_q         <= clock_q + 32'd1;
				valid_q[wr_idx] <= 1'b1;
				if (!found_q && room) occ_q <= occ_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/lfu_cache_table_top.sv
// Per request: the accept, a sweep of the single read port of the entry store
// one entry a cycle, a pipeline drain and a write-back. The write-back waits
// while an earlier result is still held. A new request is taken while that
// result waits, but not before the last request's write-back.
// Reset: asynchronous, active low; all entries invalid, capacity 16.
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// LFU key-value cache with oldest-use tie-break; controller plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_top #(
	parameter int unsigned ENTRIES = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire [lfu_pkg::CAP_W-1:0] cfg_wdata,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire                      opcode,
	input  wire [31:0]               lookup_key,
	input  wire [31:0]               write_value,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic                     hit,
	output logic [31:0]              read_value,
	output logic                     evicted,
	output logic [31:0]              evicted_key
);

	lfu_pkg::cmd_t    cmd;
	lfu_pkg::status_t status;

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lfu_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

`default_nettype wire

FILE: verif/tb_lfu_cache_table_top.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_table_top
// Self-checking bench for the LFU cache table. An in-bench cache model
// predicts hit, read value and eviction for every accepted request. Results
// are checked in order against it. Directed requests cover the edge keys,
// update, miss, count/age tie-break and shrinking capacity. Random traffic
// then runs over a skewed key pool at several capacities, with bursty gaps
// on the request side and bursty stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lfu_cache_table_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ENTRIES    = 16;
	localparam int unsigned WDOG_LIMIT = 2000;

	typedef struct packed {
		logic           hit;
		lfu_pkg::word_t read_value;
		logic           evicted;
		lfu_pkg::word_t evicted_key;
	} cache_resp_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_we      = 1'b0;
	logic [lfu_pkg::CAP_W-1:0] cfg_wdata   = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic                      opcode      = lfu_pkg::OP_GET;
	lfu_pkg::word_t            lookup_key  = '0;
	lfu_pkg::word_t            write_value = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic                      hit;
	lfu_pkg::word_t            read_value;
	logic                      evicted;
	lfu_pkg::word_t            evicted_key;

	// cache model state
	logic                      slot_valid [ENTRIES];
	lfu_pkg::word_t            slot_key   [ENTRIES];
	lfu_pkg::word_t            slot_value [ENTRIES];
	lfu_pkg::word_t            slot_count [ENTRIES];
	lfu_pkg::word_t            slot_stamp [ENTRIES];
	int unsigned               slot_used;
	lfu_pkg::word_t            use_tick;
	logic [lfu_pkg::CAP_W-1:0] cap_reg;

	cache_resp_t               lookup_results_q [$];
	cache_resp_t               resp_head;

	lfu_pkg::word_t            key_pool [32];
	int unsigned               pool_n;

	int unsigned               mismatches  = 0;
	int unsigned               get_total   = 0;
	int unsigned               put_total   = 0;
	int unsigned               hit_total   = 0;
	int unsigned               evict_total = 0;
	int unsigned               idle_cycles = 0;
	int unsigned               stall_left  = 0;
	int unsigned               gap_chance  = 0;
	bit                        idle_on     = 1'b0;

	lfu_cache_table_top #(.ENTRIES(ENTRIES)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic cache_model_reset();
		for (int i = 0; i < ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_count[i] = '0;
			slot_stamp[i] = '0;
		end
		slot_used = 0;
		use_tick  = '0;
		cap_reg   = lfu_pkg::CAP_RESET;
	endtask

	task automatic lfu_access(input logic op, input lfu_pkg::word_t key,
		input lfu_pkg::word_t val);
		cache_resp_t r;
		int unsigned slot;
		int unsigned eff_cap;
		bit          found;
		r     = '0;
		slot  = 0;
		found = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!found && slot_valid[i] && slot_key[i] == key) begin
				slot  = i;
				found = 1'b1;
			end
		end
		if (op == lfu_pkg::OP_GET) get_total++;
		else put_total++;
		if (found) begin
			r.hit = 1'b1;
			hit_total++;
			if (op == lfu_pkg::OP_GET) r.read_value = slot_value[slot];
			else slot_value[slot] = val;
			if (slot_count[slot] != '1) slot_count[slot]++;
			slot_stamp[slot] = use_tick;
			use_tick++;
		end else if (op == lfu_pkg::OP_PUT) begin
			eff_cap = (cap_reg < 1) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
			if (slot_used < eff_cap) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!found && !slot_valid[i]) begin
						slot  = i;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				slot_used++;
			end else begin
				// lowest count, then oldest use
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_valid[i]) begin
						if (!found || slot_count[i] < slot_count[slot] ||
						    (slot_count[i] == slot_count[slot] &&
						     (use_tick - slot_stamp[i]) > (use_tick - slot_stamp[slot]))) begin
							slot  = i;
							found = 1'b1;
						end
					end
				end
				r.evicted     = 1'b1;
				r.evicted_key = slot_key[slot];
				evict_total++;
			end
			slot_valid[slot] = 1'b1;
			slot_key[slot]   = key;
			slot_value[slot] = val;
			slot_count[slot] = 32'd1;
			slot_stamp[slot] = use_tick;
			use_tick++;
		end
		lookup_results_q.push_back(r);
	endtask

	task automatic send_request(input logic op, input lfu_pkg::word_t key,
		input lfu_pkg::word_t val);
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 99) < gap_chance) gap = $urandom_range(1, 7);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		lookup_key  <= key;
		write_value <= val;
		do @(posedge clk); while (in_stall !== 1'b0);
		lfu_access(op, key, val);
	endtask

	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (lookup_results_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
		settle_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cap_reg = cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_key_pool(input int unsigned n);
		pool_n = n;
		for (int i = 0; i < n; i++) key_pool[i] = $urandom;
	endtask

	task automatic test_basic_access();
		send_request(lfu_pkg::OP_GET, 32'h0000_0000, $urandom);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lfu_pkg::OP_GET, 32'h0000_0000, $urandom);
		send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, $urandom);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
		send_request(lfu_pkg::OP_GET, 32'hA5A5_A5A5, $urandom);
		send_request(lfu_pkg::OP_GET, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
	endtask

	task automatic test_lfu_eviction_order();
		write_capacity(5'd3);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0001, $urandom);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0002, $urandom);
		send_request(lfu_pkg::OP_GET, 32'h0000_0002, $urandom);
		// equal counts: the older use goes
		send_request(lfu_pkg::OP_PUT, 32'h0000_0003, $urandom);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0004, $urandom);
		send_request(lfu_pkg::OP_GET, 32'h0000_0003, $urandom);
	endtask

	task automatic test_capacity_shrink();
		write_capacity(5'd1);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0005, $urandom);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0006, $urandom);
		send_request(lfu_pkg::OP_GET, 32'h0000_0000, $urandom);
		send_request(lfu_pkg::OP_PUT, 32'h0000_0000, $urandom);
		send_request(lfu_pkg::OP_GET, 32'h0000_0006, $urandom);
	endtask

	task automatic run_cache_traffic(input logic [lfu_pkg::CAP_W-1:0] cap,
		input int unsigned n);
		lfu_pkg::word_t key;
		logic           op;
		int unsigned    pick;
		write_capacity(cap);
		fill_key_pool(cap + $urandom_range(1, 8));
		case ($urandom_range(0, 2))
			0: gap_chance = 0;
			1: gap_chance = 10;
			default: gap_chance = 35;
		endcase
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) key = $urandom;
			else key = key_pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
			op = ($urandom_range(0, 99) < 45) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
			send_request(op, key, $urandom);
		end
	endtask

	task automatic test_random_capacities();
		int unsigned caps [8];
		caps = '{16, 1, 5, 2, 12, 16, 3, 8};
		idle_on = 1'b1;
		for (int p = 0; p < 8; p++) run_cache_traffic(lfu_pkg::CAP_W'(caps[p]), 220);
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		run_cache_traffic(5'd4, 120);
		run_cache_traffic(5'd16, 120);
	endtask

	task automatic check_field(input string name, input lfu_pkg::word_t want,
		input lfu_pkg::word_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (lookup_results_q.size() == 0) begin
				$display("%0t: result with no request pending, actual hit %b value %h evicted %b key %h",
				         $time, hit, read_value, evicted, evicted_key);
				mismatches++;
			end else begin
				resp_head = lookup_results_q.pop_front();
				check_field("hit", 32'(resp_head.hit), 32'(hit));
				check_field("read_value", resp_head.read_value, read_value);
				check_field("evicted", 32'(resp_head.evicted), 32'(evicted));
				check_field("evicted_key", resp_head.evicted_key, evicted_key);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
			         lookup_results_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		cache_model_reset();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_access();
		test_lfu_eviction_order();
		test_capacity_shrink();
		test_random_capacities();
		test_back_to_back();
		settle_idle();
		repeat (ENTRIES + 8) @(posedge clk);
		$display("Ran %0d requests: %0d gets, %0d puts, %0d hits, %0d evictions",
		         get_total + put_total, get_total, put_total, hit_total, evict_total);
		$display("Capacities 1 to 16 exercised, incl. shrink below occupancy and stall bursts");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
